[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/ledseq_pkg.sv]
// Package: constants, types and helpers of the LED flash sequencer.
package ledseq_pkg;

  localparam int CHANNELS    = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int PERIOD_W    = 16;
  localparam int MASK_W      = 8;

  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [1:0] {
    PH_STOP  = 2'd0,
    PH_FLASH = 2'd1,
    PH_OFF   = 2'd2,
    PH_PAUSE = 2'd3
  } phase_t;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  localparam logic [2:0] MODE_ON     = 3'd0;
  localparam logic [2:0] MODE_SLOW   = 3'd1;
  localparam logic [2:0] MODE_SINGLE = 3'd2;
  localparam logic [2:0] MODE_DOUBLE = 3'd3;
  localparam logic [2:0] MODE_FAST   = 3'd4;

  localparam logic [1:0] REG_SLOW  = 2'd0;
  localparam logic [1:0] REG_FAST  = 2'd1;
  localparam logic [1:0] REG_PAUSE = 2'd2;

  localparam logic [PERIOD_W-1:0] SLOW_RST  = 16'd500;
  localparam logic [PERIOD_W-1:0] FAST_RST  = 16'd100;
  localparam logic [PERIOD_W-1:0] PAUSE_RST = 16'd1000;

  // Per-channel command decoded from one item
  typedef struct packed {
    logic       tick;
    logic       start;
    logic       stop;
    logic [2:0] mode;
  } chan_cmd_t;

  // Phase lengths, already in counter form
  typedef struct packed {
    count_t slow;
    count_t fast;
    count_t pause;
  } periods_t;

  // Zero acts as one; saturate when the counter is narrower than the register.
  function automatic count_t load_value(logic [PERIOD_W-1:0] p);
    logic [32:0] v;
    v = (p == '0) ? 33'd1 : 33'(p);
    if (v > CNT_MAX) begin
      v = CNT_MAX;
    end
    return v[COUNT_WIDTH-1:0];
  endfunction

endpackage

[hdl/ledseq_in_if.sv]
// Input channel interface: tick / start / stop commands.
interface ledseq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] channel;
  logic [2:0] start_mode;

  modport source (output valid, output kind, output channel, output start_mode, input ready);
  modport sink   (input valid, input kind, input channel, input start_mode, output ready);
endinterface

[hdl/ledseq_out_if.sv]
// Result channel interface: LED mask.
interface ledseq_out_if;
  logic                             valid;
  logic                             ready;
  logic [ledseq_pkg::MASK_W-1:0]    led_mask;

  modport source (output valid, output led_mask, input ready);
  modport sink   (input valid, input led_mask, output ready);
endinterface

[hdl/ledseq_chan.sv]
// One LED channel: phase sequencer with its countdown.
module ledseq_chan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  ledseq_pkg::chan_cmd_t cmd,
  input  ledseq_pkg::periods_t  periods,
  output logic                  lit_nxt
);

  ledseq_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]         mode_r, mode_nxt;
  logic               shot_r, shot_nxt;
  ledseq_pkg::count_t cnt_r, cnt_nxt;

  ledseq_pkg::count_t blink_cur, blink_new;
  logic               running;

  assign blink_cur = (mode_r == ledseq_pkg::MODE_SLOW) ? periods.slow : periods.fast;
  assign blink_new = (cmd.mode == ledseq_pkg::MODE_SLOW) ? periods.slow : periods.fast;
  assign running   = (phase_r != ledseq_pkg::PH_STOP) && (mode_r != ledseq_pkg::MODE_ON);

  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    shot_nxt  = shot_r;
    cnt_nxt   = cnt_r;
    if (en) begin
      if (cmd.tick && running) begin
        if (cnt_r <= ledseq_pkg::count_t'(1)) begin
          case (phase_r)
            ledseq_pkg::PH_FLASH: begin
              phase_nxt = ledseq_pkg::PH_OFF;
              cnt_nxt   = blink_cur;
            end
            ledseq_pkg::PH_OFF: begin
              if (mode_r == ledseq_pkg::MODE_SINGLE) begin
                phase_nxt = ledseq_pkg::PH_PAUSE;
                cnt_nxt   = periods.pause;
              end else if (mode_r == ledseq_pkg::MODE_DOUBLE && shot_r) begin
                shot_nxt  = 1'b0;
                phase_nxt = ledseq_pkg::PH_PAUSE;
                cnt_nxt   = periods.pause;
              end else begin
                if (mode_r == ledseq_pkg::MODE_DOUBLE) begin
                  shot_nxt = 1'b1;
                end
                phase_nxt = ledseq_pkg::PH_FLASH;
                cnt_nxt   = blink_cur;
              end
            end
            ledseq_pkg::PH_PAUSE: begin
              phase_nxt = ledseq_pkg::PH_FLASH;
              cnt_nxt   = blink_cur;
            end
            default: ;
          endcase
        end else begin
          cnt_nxt = cnt_r - ledseq_pkg::count_t'(1);
        end
      end else if (cmd.start) begin
        mode_nxt  = cmd.mode;
        phase_nxt = ledseq_pkg::PH_FLASH;
        if (cmd.mode == ledseq_pkg::MODE_ON) begin
          cnt_nxt = '0;
        end else begin
          if (cmd.mode == ledseq_pkg::MODE_SINGLE || cmd.mode == ledseq_pkg::MODE_DOUBLE) begin
            shot_nxt = 1'b0;
          end
          cnt_nxt = blink_new;
        end
      end else if (cmd.stop) begin
        phase_nxt = ledseq_pkg::PH_STOP;
      end
    end
  end

  assign lit_nxt = (phase_nxt == ledseq_pkg::PH_FLASH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ledseq_pkg::PH_STOP;
      mode_r  <= ledseq_pkg::MODE_ON;
      shot_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      shot_r  <= shot_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[hdl/multi_channel_led_flash_sequencer.sv]
// Top level: multi-channel LED flash sequencer.
//
//   port      dir  payload                           transfer when
//   in_ch     in   kind, channel, start_mode         in_ch.valid && in_ch.ready
//   out_ch    out  led_mask                          out_ch.valid && out_ch.ready
//   cfg_*     in   cfg_index, cfg_wdata              cfg_we
//
// One item per cycle sustained while out_ch takes results; an item passes the
// input register, then the channel update into the result register.
// All channels update in parallel in the cycle the held item leaves the input
// register, so the rate does not depend on CHANNELS.
// Synchronous active-low reset: channels stopped, periods 500/100/1000.
// A stalled result holds; the input register still takes one more item.
module multi_channel_led_flash_sequencer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ledseq_in_if.sink                            in_ch,
  ledseq_out_if.source                         out_ch,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [ledseq_pkg::PERIOD_W-1:0]      cfg_wdata
);

  // ---- period registers
  logic [ledseq_pkg::PERIOD_W-1:0] slow_r, fast_r, pause_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_r  <= ledseq_pkg::SLOW_RST;
      fast_r  <= ledseq_pkg::FAST_RST;
      pause_r <= ledseq_pkg::PAUSE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ledseq_pkg::REG_SLOW:  slow_r  <= cfg_wdata;
        ledseq_pkg::REG_FAST:  fast_r  <= cfg_wdata;
        ledseq_pkg::REG_PAUSE: pause_r <= cfg_wdata;
        default: ;  // unknown register, write dropped
      endcase
    end
  end

  ledseq_pkg::periods_t periods;
  assign periods.slow  = ledseq_pkg::load_value(slow_r);
  assign periods.fast  = ledseq_pkg::load_value(fast_r);
  assign periods.pause = ledseq_pkg::load_value(pause_r);

  // ---- input register
  logic       stg_v_r;
  logic [1:0] kind_r;
  logic [2:0] chan_r;
  logic [2:0] mode_r;

  logic                           out_v_r;
  logic [ledseq_pkg::MASK_W-1:0]  mask_r, mask_nxt;
  logic                           advance;

  // item leaves the input register when the result register can take it
  assign advance     = stg_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !stg_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_r <= in_ch.kind;
      chan_r <= in_ch.channel;
      mode_r <= in_ch.start_mode;
    end
  end

  // ---- command decode; bad modes and kind 3 fall out here
  logic is_tick, is_start, is_stop;
  assign is_tick  = (kind_r == ledseq_pkg::KIND_TICK);
  assign is_start = (kind_r == ledseq_pkg::KIND_START) && (mode_r <= ledseq_pkg::MODE_FAST);
  assign is_stop  = (kind_r == ledseq_pkg::KIND_STOP);

  logic [ledseq_pkg::CHANNELS-1:0] lit_nxt;

  for (genvar i = 0; i < ledseq_pkg::CHANNELS; i++) begin : g_chan
    ledseq_pkg::chan_cmd_t cmd;
    logic                  hit;

    // channels 8 and up are never addressed by the 3-bit channel field
    if (i < 8) begin : g_addr
      assign hit = (chan_r == 3'(i));
    end else begin : g_noaddr
      assign hit = 1'b0;
    end

    assign cmd.tick  = is_tick;
    assign cmd.start = is_start && hit;
    assign cmd.stop  = is_stop && hit;
    assign cmd.mode  = mode_r;

    ledseq_chan u_chan (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (advance),
      .cmd     (cmd),
      .periods (periods),
      .lit_nxt (lit_nxt[i])
    );
  end

  // mask shows only the first eight channels
  for (genvar b = 0; b < ledseq_pkg::MASK_W; b++) begin : g_mask
    if (b < ledseq_pkg::CHANNELS) begin : g_on
      assign mask_nxt[b] = lit_nxt[b];
    end else begin : g_off
      assign mask_nxt[b] = 1'b0;
    end
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mask_r <= mask_nxt;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.led_mask = mask_r;

endmodule

[hdl/ledseq_checker.sv]
// Port-level checker for the LED flash sequencer, bound to the top level.
`include "assert_macros.svh"

module ledseq_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [ledseq_pkg::MASK_W-1:0]       led_mask
);

  // result register is empty right after reset
  `ASSERT_CLK_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // with no result pending the input side must be open
  `ASSERT_CLK(a_ready_open, clk, rst_n, !out_valid |-> in_ready, "input blocked with empty output")

  // steady downstream ready moves an accepted item through to the output
  `ASSERT_CLK(a_latency, clk, rst_n, (in_valid && in_ready && out_ready) ##1 out_ready |=> out_valid, "accepted item did not reach output")

  // a stalled result keeps its mask
  `ASSERT_CLK(a_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(led_mask)), "stalled result changed")

endmodule

bind multi_channel_led_flash_sequencer ledseq_checker u_ledseq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .led_mask  (out_ch.led_mask)
);

[dv/tb_multi_channel_led_flash_sequencer.sv]
// Testbench for the LED flash sequencer: directed and random command streams checked per transfer.
`timescale 1ns / 1ps

module tb_multi_channel_led_flash_sequencer;

  // kind 3 has no meaning in the block; it must only echo the mask
  localparam logic [1:0] KIND_NONE  = 2'd3;
  // register index 3 is not decoded
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // highest encodable mode, outside the legal set
  localparam logic [2:0] MODE_TOP   = 3'd7;

  // Cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT = 4000;
  // Settle time after the last result, with margin for the pipeline
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] channel;
    logic [2:0] mode;
  } led_cmd_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [ledseq_pkg::PERIOD_W-1:0] cfg_wdata;

  ledseq_in_if  in_if ();
  ledseq_out_if out_if ();

  multi_channel_led_flash_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 8 ns clock, starts low so the first rising edge is at 4 ns
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the sequencer: periods plus per-channel phase state
  // ---------------------------------------------------------------------------
  logic [ledseq_pkg::PERIOD_W-1:0] slow_reg, fast_reg, pause_reg;
  ledseq_pkg::phase_t              ch_phase [ledseq_pkg::CHANNELS];
  logic [2:0]                      ch_mode  [ledseq_pkg::CHANNELS];
  logic                            ch_shot  [ledseq_pkg::CHANNELS];
  ledseq_pkg::count_t              ch_count [ledseq_pkg::CHANNELS];

  // Commands waiting for the driver, and LED masks waiting for the monitor
  led_cmd_t                      cmd_queue [$];
  logic [ledseq_pkg::MASK_W-1:0] mask_expect_q [$];

  int n_pushed;
  int n_accepted;
  int n_errors;
  int send_idle_pct;
  int recv_stall_pct;
  int stall_cycles;
  logic in_fired;
  led_cmd_t next_cmd;
  logic [ledseq_pkg::MASK_W-1:0] want_mask;

  // Period register to countdown load: zero behaves as one, and a counter
  // narrower than the register saturates.
  function automatic ledseq_pkg::count_t reload(input logic [ledseq_pkg::PERIOD_W-1:0] p);
    longint unsigned v;
    longint unsigned top;
    top = (64'd1 << ledseq_pkg::COUNT_WIDTH) - 64'd1;
    v = (p == '0) ? 64'd1 : 64'(p);
    if (v > top) begin
      v = top;
    end
    return ledseq_pkg::count_t'(v);
  endfunction

  function automatic ledseq_pkg::count_t blink_len(input logic [2:0] mode);
    return (mode == ledseq_pkg::MODE_SLOW) ? reload(slow_reg) : reload(fast_reg);
  endfunction

  // Countdown expired: step channel c to its next phase
  function automatic void advance(input int c);
    case (ch_phase[c])
      ledseq_pkg::PH_FLASH: begin
        ch_phase[c] = ledseq_pkg::PH_OFF;
        ch_count[c] = blink_len(ch_mode[c]);
      end
      ledseq_pkg::PH_OFF: begin
        if (ch_mode[c] == ledseq_pkg::MODE_SINGLE ||
            (ch_mode[c] == ledseq_pkg::MODE_DOUBLE && ch_shot[c])) begin
          // flash group done, go dark for the pause; single flash keeps its shot bit
          if (ch_mode[c] == ledseq_pkg::MODE_DOUBLE) begin
            ch_shot[c] = 1'b0;
          end
          ch_phase[c] = ledseq_pkg::PH_PAUSE;
          ch_count[c] = reload(pause_reg);
        end else begin
          // second flash of a double group, or plain blinking
          if (ch_mode[c] == ledseq_pkg::MODE_DOUBLE) begin
            ch_shot[c] = 1'b1;
          end
          ch_phase[c] = ledseq_pkg::PH_FLASH;
          ch_count[c] = blink_len(ch_mode[c]);
        end
      end
      ledseq_pkg::PH_PAUSE: begin
        ch_phase[c] = ledseq_pkg::PH_FLASH;
        ch_count[c] = blink_len(ch_mode[c]);
      end
      default: ;
    endcase
  endfunction

  // Apply one accepted command to the shadow state; returns the LED mask
  function automatic logic [ledseq_pkg::MASK_W-1:0] apply_cmd(input led_cmd_t cmd);
    logic [ledseq_pkg::MASK_W-1:0] mask;
    int c;
    mask = '0;
    case (cmd.kind)
      ledseq_pkg::KIND_TICK: begin
        for (c = 0; c < ledseq_pkg::CHANNELS; c++) begin
          // stopped and steady-on channels do not count
          if (ch_phase[c] != ledseq_pkg::PH_STOP && ch_mode[c] != ledseq_pkg::MODE_ON) begin
            if (ch_count[c] <= 1) begin
              advance(c);
            end else begin
              ch_count[c] = ch_count[c] - 1'b1;
            end
          end
        end
      end
      ledseq_pkg::KIND_START: begin
        if (cmd.channel < ledseq_pkg::CHANNELS && cmd.mode <= ledseq_pkg::MODE_FAST) begin
          ch_mode[cmd.channel]  = cmd.mode;
          ch_phase[cmd.channel] = ledseq_pkg::PH_FLASH;
          if (cmd.mode == ledseq_pkg::MODE_ON) begin
            ch_count[cmd.channel] = '0;
          end else begin
            if (cmd.mode == ledseq_pkg::MODE_SINGLE || cmd.mode == ledseq_pkg::MODE_DOUBLE) begin
              ch_shot[cmd.channel] = 1'b0;
            end
            ch_count[cmd.channel] = blink_len(cmd.mode);
          end
        end
      end
      ledseq_pkg::KIND_STOP: begin
        // countdown stays frozen on stop
        if (cmd.channel < ledseq_pkg::CHANNELS) begin
          ch_phase[cmd.channel] = ledseq_pkg::PH_STOP;
        end
      end
      default: ;
    endcase
    for (c = 0; c < ledseq_pkg::CHANNELS && c < ledseq_pkg::MASK_W; c++) begin
      if (ch_phase[c] == ledseq_pkg::PH_FLASH) begin
        mask[c] = 1'b1;
      end
    end
    return mask;
  endfunction

  // Random command: tick_pct percent ticks, the rest mostly starts with legal
  // modes, some stops, an occasional bad mode or undefined kind.
  function automatic led_cmd_t random_cmd(input int tick_pct);
    led_cmd_t cmd;
    int roll;
    cmd.channel = 3'($urandom_range(7));
    cmd.mode    = 3'($urandom_range(7));
    roll = $urandom_range(99);
    if (roll < tick_pct) begin
      cmd.kind = ledseq_pkg::KIND_TICK;
    end else begin
      roll = $urandom_range(19);
      if (roll < 12) begin
        cmd.kind = ledseq_pkg::KIND_START;
        if (roll != 0) begin
          cmd.mode = 3'($urandom_range(ledseq_pkg::MODE_FAST));
        end
      end else if (roll < 18) begin
        cmd.kind = ledseq_pkg::KIND_STOP;
      end else begin
        cmd.kind = KIND_NONE;
      end
    end
    return cmd;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: input changes on the falling edge; a held item stays up until its
  // transfer, so valid is never dropped and raised in one step.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      if (!in_if.valid || in_fired) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = cmd_queue.pop_front();
          in_if.valid      <= 1'b1;
          in_if.kind       <= next_cmd.kind;
          in_if.channel    <= next_cmd.channel;
          in_if.start_mode <= next_cmd.mode;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample on the rising edge. Results are checked before the new
  // input is predicted; the registers in between keep them from pairing up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) begin
        if (mask_expect_q.size() == 0) begin
          $error("led_mask: result with nothing pending, actual %02h", out_if.led_mask);
          n_errors++;
        end else begin
          want_mask = mask_expect_q.pop_front();
          if (out_if.led_mask !== want_mask) begin
            $error("led_mask mismatch: expected %02h, actual %02h",
                   want_mask, out_if.led_mask);
            n_errors++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        mask_expect_q.push_back(apply_cmd({in_if.kind, in_if.channel, in_if.start_mode}));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // Watchdog: any transfer on either channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("multi_channel_led_flash_sequencer verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input logic [1:0] kind, input logic [2:0] ch,
                          input logic [2:0] mode);
    cmd_queue.push_back('{kind: kind, channel: ch, mode: mode});
    n_pushed++;
  endtask

  // Hold off until every queued command has had its transfer and every mask
  // has come back, then let the pipeline settle.
  task automatic drain();
    @(negedge clk);
    while (n_accepted != n_pushed || mask_expect_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [ledseq_pkg::PERIOD_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      ledseq_pkg::REG_SLOW:  slow_reg  = val;
      ledseq_pkg::REG_FAST:  fast_reg  = val;
      ledseq_pkg::REG_PAUSE: pause_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_periods(input logic [ledseq_pkg::PERIOD_W-1:0] s,
                             input logic [ledseq_pkg::PERIOD_W-1:0] f,
                             input logic [ledseq_pkg::PERIOD_W-1:0] p);
    write_reg(ledseq_pkg::REG_SLOW, s);
    write_reg(ledseq_pkg::REG_FAST, f);
    write_reg(ledseq_pkg::REG_PAUSE, p);
    // undecoded index must leave the periods alone
    write_reg(REG_UNUSED, 16'($urandom));
  endtask

  task automatic run_random(input int n, input int tick_pct, input int snd_idle,
                            input int rcv_stall);
    @(posedge clk);
    send_idle_pct  = snd_idle;
    recv_stall_pct = rcv_stall;
    repeat (n) begin
      cmd_queue.push_back(random_cmd(tick_pct));
      n_pushed++;
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int c;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = ledseq_pkg::REG_SLOW;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.kind       = ledseq_pkg::KIND_TICK;
    in_if.channel    = '0;
    in_if.start_mode = ledseq_pkg::MODE_ON;
    out_if.ready     = 1'b0;
    n_pushed         = 0;
    n_accepted       = 0;
    n_errors         = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    stall_cycles     = 0;
    slow_reg         = ledseq_pkg::SLOW_RST;
    fast_reg         = ledseq_pkg::FAST_RST;
    pause_reg        = ledseq_pkg::PAUSE_RST;
    for (c = 0; c < ledseq_pkg::CHANNELS; c++) begin
      ch_phase[c] = ledseq_pkg::PH_STOP;
      ch_mode[c]  = ledseq_pkg::MODE_ON;
      ch_shot[c]  = 1'b0;
      ch_count[c] = '0;
    end

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset periods: every mode, field extremes, ignored commands
    @(posedge clk);
    push_cmd(ledseq_pkg::KIND_START, 3'd0, ledseq_pkg::MODE_ON);
    push_cmd(ledseq_pkg::KIND_START, 3'd7, ledseq_pkg::MODE_FAST);
    push_cmd(ledseq_pkg::KIND_START, 3'd1, ledseq_pkg::MODE_SLOW);
    push_cmd(ledseq_pkg::KIND_START, 3'd2, ledseq_pkg::MODE_SINGLE);
    push_cmd(ledseq_pkg::KIND_START, 3'd3, ledseq_pkg::MODE_DOUBLE);
    push_cmd(ledseq_pkg::KIND_TICK, 3'd7, MODE_TOP);
    push_cmd(KIND_NONE, 3'd7, MODE_TOP);                          // undefined kind
    push_cmd(ledseq_pkg::KIND_START, 3'd4, MODE_TOP);             // illegal mode
    push_cmd(ledseq_pkg::KIND_START, 3'd5, ledseq_pkg::MODE_FAST + 3'd1);
    push_cmd(ledseq_pkg::KIND_STOP, 3'd7, ledseq_pkg::MODE_ON);
    push_cmd(ledseq_pkg::KIND_TICK, 3'd0, ledseq_pkg::MODE_ON);
    drain();

    // Reset periods with mostly ticks, so 100-tick fast phases expire
    run_random(120, 90, 0, 0);

    // Directed, short periods: fast written as zero (one tick), double flash
    // group through to its pause, restart of a stopped group, steady on
    set_periods(16'd1, 16'd0, 16'd2);
    @(posedge clk);
    push_cmd(ledseq_pkg::KIND_START, 3'd2, ledseq_pkg::MODE_SINGLE);
    push_cmd(ledseq_pkg::KIND_START, 3'd3, ledseq_pkg::MODE_DOUBLE);
    push_cmd(ledseq_pkg::KIND_START, 3'd4, ledseq_pkg::MODE_FAST);
    push_cmd(ledseq_pkg::KIND_START, 3'd1, ledseq_pkg::MODE_SLOW);
    push_cmd(ledseq_pkg::KIND_START, 3'd0, ledseq_pkg::MODE_ON);
    repeat (6) push_cmd(ledseq_pkg::KIND_TICK, 3'd0, ledseq_pkg::MODE_ON);
    push_cmd(ledseq_pkg::KIND_STOP, 3'd3, ledseq_pkg::MODE_ON);
    push_cmd(ledseq_pkg::KIND_START, 3'd3, ledseq_pkg::MODE_DOUBLE);
    push_cmd(ledseq_pkg::KIND_TICK, 3'd0, ledseq_pkg::MODE_ON);
    drain();

    // Random phases across period settings and handshake pressure
    set_periods(16'd3, 16'd1, 16'd4);
    run_random(130, 65, 56, 0);

    set_periods(16'd2, 16'd0, 16'd1);
    run_random(130, 65, 0, 56);

    // largest periods on slow and pause, fast still short
    set_periods(16'hFFFF, 16'd1, 16'hFFFF);
    run_random(100, 65, 18, 18);

    set_periods(16'd5, 16'd2, 16'd3);
    run_random(130, 70, 0, 0);

    // split in two: the sender waits for all masks in between
    set_periods(16'd1, 16'd3, 16'd0);
    run_random(50, 65, 0, 56);
    run_random(50, 65, 56, 0);

    if (n_errors == 0) begin
      $display("multi_channel_led_flash_sequencer verification clean");
    end else begin
      $display("multi_channel_led_flash_sequencer verification failed");
    end
    $finish;
  end

endmodule
